// ===== hdl/swf_pkg.sv =====
`timescale 1ns / 1ps

package swf_pkg;

    localparam int C_BLOCK_SIZE   = 16;
    localparam int C_WINDOW_WORDS = 32;
    localparam int C_SEARCH_X     = 16;
    localparam int C_SEARCH_Y     = 16;

    localparam int C_COL_W   = $clog2(C_WINDOW_WORDS);
    localparam int C_LINES_W = $clog2(C_BLOCK_SIZE + 2 * C_SEARCH_Y + 1);
    localparam int C_BURST_W = $clog2((C_BLOCK_SIZE + C_SEARCH_X) / 4 + 1);
    localparam int C_TOP_W   = $clog2(C_SEARCH_Y + 1);

    localparam logic [C_BURST_W-1:0] C_BURST_WIDE   =
        C_BURST_W'((C_BLOCK_SIZE + C_SEARCH_X) / 4);
    localparam logic [C_BURST_W-1:0] C_BURST_NARROW = C_BURST_W'(C_BLOCK_SIZE / 4);
    localparam logic [C_COL_W-1:0]   C_WCOL_START   = C_COL_W'(C_SEARCH_X / 4);

    localparam logic [0:0] C_REG_MB_COLS = 1'b0;
    localparam logic [0:0] C_REG_MB_ROWS = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic intra;
        logic last;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/swf_in_if.sv =====
`timescale 1ns / 1ps

interface swf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] mb_col;
    logic [7:0] mb_row;
    logic       intra_frame;

    modport source (output valid, output mb_col, output mb_row, output intra_frame,
                    input ready);
    modport sink (input valid, input mb_col, input mb_row, input intra_frame,
                  output ready);
endinterface

// ===== hdl/swf_out_if.sv =====
`timescale 1ns / 1ps

interface swf_out_if;
    logic        valid;
    logic        ready;
    logic [21:0] ref_word_addr;
    logic [5:0]  window_row;
    logic [4:0]  window_col_start;
    logic [3:0]  burst_words;
    logic        last_line;

    modport source (output valid, output ref_word_addr, output window_row,
                    output window_col_start, output burst_words, output last_line,
                    input ready);
    modport sink (input valid, input ref_word_addr, input window_row,
                  input window_col_start, input burst_words, input last_line,
                  output ready);
endinterface

// ===== hdl/swf_ctrl.sv =====
`timescale 1ns / 1ps

module swf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output swf_pkg::t_cmd o_cmd,
    input  swf_pkg::t_sts i_sts
);
    import swf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = i_sts.intra ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/swf_dp.sv =====
`timescale 1ns / 1ps

module swf_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  logic [7:0]    i_mb_col,
    input  logic [7:0]    i_mb_row,
    input  logic          i_intra_frame,
    input  swf_pkg::t_cmd i_cmd,
    output swf_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [21:0]   o_ref_word_addr,
    output logic [5:0]    o_window_row,
    output logic [4:0]    o_window_col_start,
    output logic [3:0]    o_burst_words,
    output logic          o_last_line
);
    import swf_pkg::*;

    logic [7:0]           r_mb_cols;
    logic [7:0]           r_mb_rows;
    logic [9:0]           r_fc;
    logic [C_COL_W-1:0]   r_wcol;

    logic [7:0]           r_col;
    logic [7:0]           r_row;
    logic                 r_intra;

    logic [11:0]          r_base_row;
    logic [9:0]           r_fc_old;
    logic [9:0]           r_wpl;
    logic [C_LINES_W-1:0] r_lines;
    logic [C_BURST_W-1:0] r_burst;
    logic [C_COL_W-1:0]   r_wcol_line;
    logic [5:0]           r_wrow;
    logic [21:0]          r_addr;
    logic [C_LINES_W-1:0] r_line;
    logic                 r_out_valid;

    logic [11:0]          w_row16;
    logic [12:0]          w_row1_16;
    logic [13:0]          w_below_lhs;
    logic [12:0]          w_rows16;
    logic [C_TOP_W-1:0]   w_top;
    logic [C_TOP_W-1:0]   w_below;
    logic [9:0]           w_wpl;
    logic [C_BURST_W-1:0] w_burst_nom;
    logic [10:0]          w_burst_sum;
    logic [C_BURST_W-1:0] w_burst;
    logic                 w_last_col;
    logic [C_COL_W-1:0]   w_wcol_line;
    logic [21:0]          w_prod;
    logic                 w_last;
    logic                 w_out_free;

    always_comb begin
        w_row16     = {r_row, 4'b0000};
        w_row1_16   = {(9'(r_row) + 9'd1), 4'b0000};
        w_below_lhs = 14'(w_row1_16) + 14'(C_SEARCH_Y);
        w_rows16    = {1'b0, r_mb_rows, 4'b0000};
        w_top       = (w_row16 < 12'(C_SEARCH_Y)) ? C_TOP_W'(w_row16) : C_TOP_W'(C_SEARCH_Y);
        if (w_below_lhs >= 14'(w_rows16)) begin
            w_below = (w_rows16 > w_row1_16) ? C_TOP_W'(w_rows16 - w_row1_16) : '0;
        end else begin
            w_below = C_TOP_W'(C_SEARCH_Y);
        end
        w_wpl       = {r_mb_cols, 2'b00};
        w_burst_nom = (r_col == 8'd0) ? C_BURST_WIDE : C_BURST_NARROW;
        w_burst_sum = 11'(r_fc) + 11'(w_burst_nom);
        if (w_burst_sum > 11'(w_wpl)) begin
            w_burst = (w_wpl > r_fc) ? C_BURST_W'(w_wpl - r_fc) : '0;
        end else begin
            w_burst = w_burst_nom;
        end
        w_last_col  = (r_mb_cols != 8'd0) && (r_col == (r_mb_cols - 8'd1));
        w_wcol_line = (r_col == 8'd0) ? C_WCOL_START : r_wcol;
        w_prod      = 22'(r_base_row) * 22'(r_wpl);
        w_last      = (r_line == (r_lines - C_LINES_W'(1)));
        w_out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mb_cols   <= 8'd1;
            r_mb_rows   <= 8'd1;
            r_fc        <= '0;
            r_wcol      <= C_WCOL_START;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    C_REG_MB_COLS: r_mb_cols <= i_cfg_data;
                    C_REG_MB_ROWS: r_mb_rows <= i_cfg_data;
                    default:       r_mb_cols <= r_mb_cols;
                endcase
            end
            if (i_cmd.prep) begin
                r_fc <= w_last_col ? 10'd0 : 10'(r_fc + 10'(w_burst));
                if (!r_intra) begin
                    r_wcol <= C_COL_W'(w_wcol_line + C_COL_W'(w_burst));
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col   <= i_mb_col;
            r_row   <= i_mb_row;
            r_intra <= i_intra_frame;
        end
        if (i_cmd.prep) begin
            r_base_row  <= w_row16 - 12'(w_top);
            r_fc_old    <= r_fc;
            r_wpl       <= w_wpl;
            r_lines     <= C_LINES_W'(w_top) + C_LINES_W'(C_BLOCK_SIZE) + C_LINES_W'(w_below);
            r_burst     <= w_burst;
            r_wcol_line <= w_wcol_line;
            r_wrow      <= 6'(C_SEARCH_Y) - 6'(w_top);
        end
        if (i_cmd.mul) begin
            r_addr <= w_prod + 22'(r_fc_old);
            r_line <= '0;
        end
        if (i_cmd.emit) begin
            o_ref_word_addr    <= r_addr;
            o_window_row       <= r_wrow;
            o_window_col_start <= 5'(r_wcol_line);
            o_burst_words      <= 4'(r_burst);
            o_last_line        <= w_last;
            r_addr             <= r_addr + 22'(r_wpl);
            r_wrow             <= r_wrow + 6'd1;
            r_line             <= r_line + C_LINES_W'(1);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.intra    = r_intra;
    assign o_sts.last     = w_last;
    assign o_sts.out_free = w_out_free;

endmodule

// ===== hdl/search_window_fetch_address_gen.sv =====
`timescale 1ns / 1ps

// Search window fetch address generator. Each transfer on the input channel names
// one macroblock by column, row and intra flag. For a non-intra macroblock the block
// produces one transfer per reference line on the output channel, carrying the frame
// word address, the window buffer row, the first window column, the burst width in
// words and a flag on the final line. An intra macroblock produces no output but still
// advances the running fetch column.
// Frame size is set through the write port (index 0: width, index 1: height, both in
// macroblocks); the user must write it only while the block is idle, and the block
// itself does not enforce this. Timing: after an input transfer the block does the
// clamping arithmetic in a prep state and the address multiply in a multiply state,
// then emits one line per cycle while the output is not stalled. A non-intra
// macroblock occupies the block for its lines (16 plus the clamped rows above and
// below, at most 48 here) and those two states; an intra one only for the prep state.
// Results sit in an output register, so the next macroblock is accepted while the
// last line still waits. A stall on the output holds the current line and pauses the
// sequencer. Reset restores both frame dimensions to 1, the fetch column to 0 and the
// window column to its start value.
module search_window_fetch_address_gen (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    swf_in_if.sink     i_mb,
    swf_out_if.source  o_line
);
    import swf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    swf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_mb.valid),
        .o_in_ready (i_mb.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    swf_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_mb_col           (i_mb.mb_col),
        .i_mb_row           (i_mb.mb_row),
        .i_intra_frame      (i_mb.intra_frame),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_out_valid        (o_line.valid),
        .i_out_ready        (o_line.ready),
        .o_ref_word_addr    (o_line.ref_word_addr),
        .o_window_row       (o_line.window_row),
        .o_window_col_start (o_line.window_col_start),
        .o_burst_words      (o_line.burst_words),
        .o_last_line        (o_line.last_line)
    );

endmodule

// ===== sim/search_window_fetch_checker.sv =====
`timescale 1ns / 1ps

module search_window_fetch_checker
    import swf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    swf_in_if          i_mb,
    swf_out_if         i_line,
    output int         o_fail_count,
    output int         o_lines_pending
);

    typedef struct packed {
        logic [21:0] addr;
        logic [5:0]  win_row;
        logic [4:0]  win_col;
        logic [3:0]  burst;
        logic        is_last;
    } fetch_line_t;

    fetch_line_t expected_lines[$];

    logic [7:0] frame_cols;
    logic [7:0] frame_rows;
    logic [9:0] fetch_col;
    logic [4:0] window_col;

    initial begin
        o_fail_count    = 0;
        o_lines_pending = 0;
    end

    task automatic plan_fetch_lines(input logic [7:0] col_in, input logic [7:0] row_in,
                                    input logic intra);
        int col;
        int row;
        int rows_above;
        int rows_below;
        int lines;
        int words;
        int burst;
        int fc;
        int start;
        fetch_line_t ln;
        col = col_in;
        row = row_in;
        rows_above = C_SEARCH_Y;
        rows_below = C_SEARCH_Y;
        if (row * C_BLOCK_SIZE < rows_above) begin
            rows_above = row * C_BLOCK_SIZE;
        end
        if ((row + 1) * C_BLOCK_SIZE + rows_below >= int'(frame_rows) * C_BLOCK_SIZE) begin
            rows_below = int'(frame_rows) * C_BLOCK_SIZE - (row + 1) * C_BLOCK_SIZE;
            if (rows_below < 0) begin
                rows_below = 0;
            end
        end
        lines = rows_above + C_BLOCK_SIZE + rows_below;

        words = int'(frame_cols) * (C_BLOCK_SIZE / 4);
        fc = int'(fetch_col);
        burst = (col == 0) ? (C_BLOCK_SIZE + C_SEARCH_X) / 4 : C_BLOCK_SIZE / 4;
        if (fc + burst > words) begin
            burst = words - fc;
            if (burst < 0) begin
                burst = 0;
            end
        end
        start = (row * C_BLOCK_SIZE - rows_above) * words + fc;

        fetch_col = 10'(fc + burst);
        if (col == int'(frame_cols) - 1) begin
            fetch_col = '0;
        end
        if (intra) begin
            return;
        end

        if (col == 0) begin
            window_col = 5'(C_SEARCH_X / 4);
        end
        for (int j = 0; j < lines; j++) begin
            ln.addr    = 22'(start + j * words);
            ln.win_row = 6'(C_SEARCH_Y - rows_above + j);
            ln.win_col = window_col;
            ln.burst   = 4'(burst);
            ln.is_last = (j == lines - 1);
            expected_lines.push_back(ln);
        end
        window_col = 5'(int'(window_col) + burst);
    endtask

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        fetch_line_t want;
        if (!i_rst_n) begin
            frame_cols = 8'd1;
            frame_rows = 8'd1;
            fetch_col  = '0;
            window_col = 5'(C_SEARCH_X / 4);
            expected_lines.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    C_REG_MB_COLS: frame_cols = i_cfg_data;
                    C_REG_MB_ROWS: frame_rows = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_line.valid && i_line.ready) begin
                if (expected_lines.size() == 0) begin
                    $error("line transfer with no line expected, address %0d",
                           i_line.ref_word_addr);
                    o_fail_count++;
                end else begin
                    want = expected_lines.pop_front();
                    compare_field("ref_word_addr", want.addr, i_line.ref_word_addr);
                    compare_field("window_row", want.win_row, i_line.window_row);
                    compare_field("window_col_start", want.win_col, i_line.window_col_start);
                    compare_field("burst_words", want.burst, i_line.burst_words);
                    compare_field("last_line", want.is_last, i_line.last_line);
                end
            end
            if (i_mb.valid && i_mb.ready) begin
                plan_fetch_lines(i_mb.mb_col, i_mb.mb_row, i_mb.intra_frame);
            end
        end
        o_lines_pending = expected_lines.size();
    end

endmodule

// ===== sim/search_window_fetch_address_gen_test.sv =====
`timescale 1ns / 1ps

module search_window_fetch_address_gen_test;
    import swf_pkg::*;

    localparam int STALL_MAX      = 17;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 26;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;

    int   fail_count;
    int   lines_pending;
    int   idle_cycles   = 0;
    int   tx_gap_max    = STALL_MAX;
    int   rx_stall_max  = STALL_MAX;
    logic hold_request  = 1'b0;

    swf_in_if  mb_ch ();
    swf_out_if line_ch ();

    search_window_fetch_address_gen i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mb       (mb_ch),
        .o_line     (line_ch)
    );

    search_window_fetch_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mb            (mb_ch),
        .i_line          (line_ch),
        .o_fail_count    (fail_count),
        .o_lines_pending (lines_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((mb_ch.valid && mb_ch.ready) || (line_ch.valid && line_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("search_window_fetch_address_gen test failed");
            $finish;
        end
    end

    initial begin : line_receiver
        int stall;
        line_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request  = 1'b0;
                line_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = $urandom_range(rx_stall_max, 0);
            if (stall > 0) begin
                line_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            line_ch.ready = 1'b1;
            do @(posedge i_clk); while (!line_ch.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_mb(input logic [7:0] col, input logic [7:0] row, input logic intra);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            mb_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        mb_ch.mb_col      = col;
        mb_ch.mb_row      = row;
        mb_ch.intra_frame = intra;
        mb_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!mb_ch.ready);
        @(negedge i_clk);
    endtask

    // Config may only change once every line has left and an intra item has cleared.
    task automatic drain_block();
        mb_ch.valid = 1'b0;
        while (lines_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_frame_size(input logic [7:0] cols, input logic [7:0] rows);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = C_REG_MB_COLS;
        i_cfg_data = cols;
        @(negedge i_clk);
        i_cfg_idx  = C_REG_MB_ROWS;
        i_cfg_data = rows;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    initial begin
        int         cols;
        int         rows;
        int         walk_col;
        int         walk_row;
        logic [7:0] col;
        logic [7:0] row;
        mb_ch.valid       = 1'b0;
        mb_ch.mb_col      = 8'd0;
        mb_ch.mb_row      = 8'd0;
        mb_ch.intra_frame = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_mb(8'd0, 8'd0, 1'b0);
        drain_block();

        set_frame_size(8'd255, 8'd255);
        send_mb(8'd0, 8'd0, 1'b0);
        send_mb(8'd1, 8'd1, 1'b0);
        send_mb(8'd2, 8'd254, 1'b0);
        send_mb(8'd3, 8'd255, 1'b1);
        send_mb(8'd4, 8'd255, 1'b0);
        send_mb(8'd254, 8'd128, 1'b0);
        send_mb(8'd255, 8'd7, 1'b0);
        send_mb(8'd0, 8'd3, 1'b1);
        send_mb(8'd0, 8'd3, 1'b0);
        drain_block();

        // A column past the frame edge after a wide burst leaves nothing to fetch.
        set_frame_size(8'd2, 8'd3);
        send_mb(8'd0, 8'd0, 1'b0);
        send_mb(8'd5, 8'd1, 1'b0);
        send_mb(8'd1, 8'd2, 1'b0);
        drain_block();

        set_frame_size(8'd0, 8'd2);
        send_mb(8'd0, 8'd1, 1'b0);
        send_mb(8'd0, 8'd1, 1'b1);
        send_mb(8'd3, 8'd0, 1'b0);
        drain_block();

        set_frame_size(8'd3, 8'd0);
        send_mb(8'd0, 8'd0, 1'b0);
        send_mb(8'd2, 8'd1, 1'b0);
        drain_block();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin cols = 255; rows = 255; end
                1: begin cols = 1; rows = 1; end
                2: begin cols = 0; rows = 4; end
                3: begin cols = 6; rows = 0; end
                7: begin cols = 255; rows = $urandom_range(255, 1); end
                default: begin
                    cols = $urandom_range(12, 1);
                    rows = $urandom_range(12, 1);
                end
            endcase
            set_frame_size(8'(cols), 8'(rows));
            tx_gap_max   = (phase % 3 == 1) ? 0 : STALL_MAX;
            rx_stall_max = (phase % 4 == 2) ? 0 : STALL_MAX;
            if (phase == 1) begin
                hold_request = 1'b1;
            end
            if (cols == 0) begin
                cols = 1;
            end
            if (rows == 0) begin
                rows = 1;
            end
            walk_col = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(cols - 1, 0);
            walk_row = $urandom_range(rows - 1, 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(9, 0) < 8) begin
                    col = 8'(walk_col);
                    row = 8'(walk_row);
                    walk_col++;
                    if (walk_col >= cols) begin
                        walk_col = 0;
                        walk_row = (walk_row + 1 >= rows) ? 0 : walk_row + 1;
                    end
                end else begin
                    col = 8'($urandom_range(255, 0));
                    row = 8'($urandom_range(255, 0));
                end
                send_mb(col, row, $urandom_range(4, 0) == 0);
            end
            drain_block();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("search_window_fetch_address_gen test passed");
        end else begin
            $display("search_window_fetch_address_gen test failed");
        end
        $finish;
    end

endmodule
